[rtl/sobmd_pkg.sv]
// Package of shared constants, codes and stage payload types for the Sobel magnitude block.
package sobmd_pkg;

    // Gradient word width and the widths that follow from it.
    localparam int GRAD_WIDTH = 11;
    localparam int SQ_W       = 2 * GRAD_WIDTH - 1;
    localparam int SUM_W      = 2 * GRAD_WIDTH;

    // Square root datapath: 16-bit radicand, 8-bit root.
    localparam int RAD_W        = 16;
    localparam int ROOT_W       = 8;
    localparam int REM_W        = ROOT_W + 2;
    localparam int SQRT_STEPS   = 2;
    localparam int SQRT_STAGES  = ROOT_W / SQRT_STEPS;
    localparam int NUM_STAGES   = SQRT_STAGES + 2;

    typedef enum logic [1:0] {
        DIR_0   = 2'd0,
        DIR_45  = 2'd1,
        DIR_90  = 2'd2,
        DIR_135 = 2'd3
    } t_dir;

    // First stage payload: absolute values and their squares.
    typedef struct packed {
        logic [GRAD_WIDTH-1:0] ax;
        logic [GRAD_WIDTH-1:0] ay;
        logic [SQ_W-1:0]       sqx;
        logic [SQ_W-1:0]       sqy;
        logic                  gx_neg;
        logic                  gx_zero;
    } t_grad;

    // Square root stage payload: radicand bits still to consume, partial result.
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              sat;
        t_dir              dir;
    } t_sqrt;

endpackage

[rtl/sobmd_if.sv]
// Valid/ready channel interfaces for gradient requests and result requests.
interface sobmd_grad_if
    import sobmd_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [GRAD_WIDTH-1:0] grad_x;
    logic signed [GRAD_WIDTH-1:0] grad_y;

    modport source (output valid, output grad_x, output grad_y, input ready);
    modport sink   (input valid, input grad_x, input grad_y, output ready);
endinterface

interface sobmd_res_if
    import sobmd_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [7:0]  magnitude;
    logic [1:0]  direction;

    modport source (output valid, output magnitude, output direction, input ready);
    modport sink   (input valid, input magnitude, input direction, output ready);
endinterface

[rtl/sobmd_grad_stage.sv]
// First pipeline stage: gradient absolute values and their squares.
module sobmd_grad_stage
    import sobmd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [GRAD_WIDTH-1:0] i_grad_x,
    input  logic signed [GRAD_WIDTH-1:0] i_grad_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_grad                        o_data
);

    logic  r_valid;
    t_grad r_data;
    t_grad n_data;

    always_comb begin
        n_data.gx_neg  = i_grad_x[GRAD_WIDTH-1];
        n_data.gx_zero = (i_grad_x == '0);
        // The most negative value negates to itself, whose unsigned reading is correct.
        n_data.ax  = i_grad_x[GRAD_WIDTH-1] ? (~i_grad_x + 1'b1) : i_grad_x;
        n_data.ay  = i_grad_y[GRAD_WIDTH-1] ? (~i_grad_y + 1'b1) : i_grad_y;
        n_data.sqx = SQ_W'(n_data.ax) * SQ_W'(n_data.ax);
        n_data.sqy = SQ_W'(n_data.ay) * SQ_W'(n_data.ay);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/sobmd_sum_stage.sv]
// Second pipeline stage: squared sum, saturation test and direction quantization.
module sobmd_sum_stage
    import sobmd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_grad i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_sqrt o_data
);

    logic             r_valid;
    t_sqrt            r_data;
    t_sqrt            n_data;
    logic [SUM_W-1:0] sum;

    always_comb begin
        sum         = SUM_W'(i_data.sqx) + SUM_W'(i_data.sqy);
        n_data.rad  = sum[RAD_W-1:0];
        n_data.rem  = '0;
        n_data.root = '0;
        n_data.sat  = |sum[SUM_W-1:RAD_W];
        // A nonzero horizontal gradient already implies a nonzero magnitude.
        if (i_data.gx_zero) begin
            n_data.dir = DIR_0;
        end else if ({1'b0, i_data.ay} > {i_data.ax, 1'b0}) begin
            n_data.dir = DIR_0;
        end else if ({1'b0, i_data.ax} > {i_data.ay, 1'b0}) begin
            n_data.dir = DIR_90;
        end else if (i_data.gx_neg) begin
            n_data.dir = DIR_135;
        end else begin
            n_data.dir = DIR_45;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/sobmd_sqrt_stage.sv]
// Square root pipeline stage: resolves two root bits per stage by digit recurrence.
module sobmd_sqrt_stage
    import sobmd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_sqrt i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_sqrt o_data
);

    logic  r_valid;
    t_sqrt r_data;
    t_sqrt n_data;

    always_comb begin
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        n_data = i_data;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            acc   = {n_data.rem, n_data.rad[RAD_W-1 -: 2]};
            trial = (REM_W + 2)'({n_data.root, 2'b01});
            if (acc >= trial) begin
                n_data.rem  = REM_W'(acc - trial);
                n_data.root = {n_data.root[ROOT_W-2:0], 1'b1};
            end else begin
                n_data.rem  = REM_W'(acc);
                n_data.root = {n_data.root[ROOT_W-2:0], 1'b0};
            end
            n_data.rad = {n_data.rad[RAD_W-3:0], 2'b00};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // The partial remainder never exceeds twice the partial root.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.rem <= REM_W'({r_data.root, 1'b0})))
        else $error("sqrt remainder exceeds twice the partial root");

endmodule

[rtl/sobel_magnitude_direction.sv]
// Top level of the Sobel gradient magnitude and direction quantizer.
//
// Usage: each request on i_grad carries one pixel's signed horizontal and
// vertical Sobel gradients. For each one, exactly one request leaves on o_res
// with the floor square root of gx*gx + gy*gy, saturated at 255, and a two-bit
// direction code (0, 45, 90 or 135 degrees). Pixels are independent.
// The datapath is a six-stage pipeline: absolute values and squares, then the
// squared sum with the saturation and direction tests, then four square root
// stages that settle two root bits each. The last square root register is the
// output register, from which each result is offered to o_res.
// Throughput is one pixel per clock while o_res is ready; the per-stage depth
// is set by the two dependent compare-subtract steps in each square root stage.
// Each stage carries its own valid bit and accepts a new request whenever it
// is empty or its successor moves, so bubbles close up and a receiver stall
// only holds off new requests once all six stages are full. Nothing is lost
// or repeated across a stall.
// A synchronous active-low reset clears all valid bits; payload registers
// are not reset.
module sobel_magnitude_direction
    import sobmd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sobmd_grad_if.sink    i_grad,
    sobmd_res_if.source   o_res
);

    t_grad                  w_grad;
    logic                   w_grad_valid;
    logic                   w_grad_ready;
    t_sqrt                  w_sq    [SQRT_STAGES+1];
    logic [SQRT_STAGES:0]   w_sq_valid;
    logic [SQRT_STAGES:0]   w_sq_ready;
    t_sqrt                  w_last;

    sobmd_grad_stage u_grad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_grad.valid),
        .o_ready  (i_grad.ready),
        .i_grad_x (i_grad.grad_x),
        .i_grad_y (i_grad.grad_y),
        .o_valid  (w_grad_valid),
        .i_ready  (w_grad_ready),
        .o_data   (w_grad)
    );

    sobmd_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_grad_valid),
        .o_ready (w_grad_ready),
        .i_data  (w_grad),
        .o_valid (w_sq_valid[0]),
        .i_ready (w_sq_ready[0]),
        .o_data  (w_sq[0])
    );

    // Chain of square root stages; stage k reads link k and drives link k+1.
    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        sobmd_sqrt_stage u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sq_valid[g]),
            .o_ready (w_sq_ready[g]),
            .i_data  (w_sq[g]),
            .o_valid (w_sq_valid[g+1]),
            .i_ready (w_sq_ready[g+1]),
            .o_data  (w_sq[g+1])
        );
    end

    assign w_last                  = w_sq[SQRT_STAGES];
    assign w_sq_ready[SQRT_STAGES] = o_res.ready;
    assign o_res.valid             = w_sq_valid[SQRT_STAGES];
    assign o_res.magnitude         = w_last.sat ? 8'hFF : w_last.root;
    assign o_res.direction         = w_last.dir;

    // Back pressure reaches the input only when every stage holds a pixel.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_grad.ready |-> (w_grad_valid && (&w_sq_valid)))
        else $error("input blocked while the pipeline has an empty stage");

    // Reset empties the pipeline.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result offered right after reset");

    // A zero magnitude only comes from two zero gradients, whose direction is 0.
    a_zero_mag_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.magnitude == 8'd0)) |-> (o_res.direction == DIR_0))
        else $error("zero magnitude with nonzero direction");

endmodule

[dv/sobel_magnitude_direction_tb.sv]
// Self-checking testbench for the Sobel gradient magnitude and direction quantizer.
`timescale 1ns / 1ps

module sobel_magnitude_direction_tb
    import sobmd_pkg::*;
();

    // One pending gradient request, with the idle cycles the sender spends
    // after it is taken and a flag that holds it back until the pipe drains.
    typedef struct {
        logic signed [GRAD_WIDTH-1:0] gx;
        logic signed [GRAD_WIDTH-1:0] gy;
        int                           gap;
        bit                           drain_first;
    } t_pixel;

    // One expected result request.
    typedef struct packed {
        logic [7:0] magnitude;
        t_dir       direction;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    sobmd_grad_if grad_ch ();
    sobmd_res_if  res_ch ();

    sobel_magnitude_direction uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_grad  (grad_ch.sink),
        .o_res   (res_ch.source)
    );

    t_pixel  pixel_q[$];
    t_result pending_results[$];
    int      error_count;

    // Counters and flags of the driver and the monitor, save sink_hold, set by the hold process.
    int src_gap;
    int snk_stall;
    int results_seen;
    bit sink_calm;
    bit sink_hold;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Gradient magnitude and direction of one pixel: bitwise floor square
    // root of the squared sum with saturation, then the two-to-one ratio test.
    function automatic t_result sobel_point(input logic signed [GRAD_WIDTH-1:0] gx,
                                            input logic signed [GRAD_WIDTH-1:0] gy);
        int          ax;
        int          ay;
        int unsigned sum;
        int unsigned root;
        int unsigned trial;
        t_result     r;
        ax = (gx < 0) ? -int'(gx) : int'(gx);
        ay = (gy < 0) ? -int'(gy) : int'(gy);
        sum = ax * ax + ay * ay;
        root = 0;
        if (sum >= 65536) begin
            root = 255;
        end else begin
            for (int b = 7; b >= 0; b--) begin
                trial = root | (1 << b);
                if (trial * trial <= sum) root = trial;
            end
        end
        r.magnitude = root[7:0];
        r.direction = DIR_0;
        // A zero horizontal gradient, or a zero magnitude, always gives 0 degrees.
        if (root != 0 && gx != 0) begin
            if (ay > 2 * ax) begin
                r.direction = DIR_0;
            end else if (ax > 2 * ay) begin
                r.direction = DIR_90;
            end else begin
                r.direction = (gx > 0) ? DIR_45 : DIR_135;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s, got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic add_pixel(input int gx, input int gy, input int gap, input bit drain_first);
        t_pixel p;
        p.gx          = gx[GRAD_WIDTH-1:0];
        p.gy          = gy[GRAD_WIDTH-1:0];
        p.gap         = gap;
        p.drain_first = drain_first;
        pixel_q.push_back(p);
    endtask

    // Driver: offers the head of the pixel queue and keeps valid high until
    // the request is taken. A taken request is predicted at once, so the
    // expected results stay in acceptance order.
    always @(posedge i_clk) begin
        t_pixel nxt;
        logic   offer;
        if (!i_rst_n) begin
            grad_ch.valid <= 1'b0;
            src_gap = 0;
        end else begin
            offer = grad_ch.valid;
            if (grad_ch.valid && grad_ch.ready) begin
                pending_results.push_back(sobel_point(grad_ch.grad_x, grad_ch.grad_y));
                offer = 1'b0;
            end
            if (!offer) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pixel_q.size() > 0 &&
                             !(pixel_q[0].drain_first && pending_results.size() > 0)) begin
                    nxt = pixel_q.pop_front();
                    grad_ch.grad_x <= nxt.gx;
                    grad_ch.grad_y <= nxt.gy;
                    src_gap = nxt.gap;
                    offer = 1'b1;
                end
            end
            // Valid gets exactly one assignment per edge, so a back-to-back
            // request never sees a low pulse.
            grad_ch.valid <= offer;
        end
    end

    // Monitor: checks each taken result against the oldest expectation, then
    // draws a stall before the next one. Every hundred results it may switch
    // to a stretch with no stalls. A long hold from the process below keeps
    // ready low on top of that.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            snk_stall = 0;
            results_seen = 0;
            sink_calm = 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request pending", res_ch.magnitude, -1);
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.magnitude !== want.magnitude)
                        report_mismatch("magnitude", res_ch.magnitude, want.magnitude);
                    if (res_ch.direction !== want.direction)
                        report_mismatch("direction", res_ch.direction, want.direction);
                end
                results_seen++;
                if (results_seen % 100 == 0) sink_calm = ($urandom_range(0, 2) == 0);
                snk_stall = sink_calm ? 0 : $urandom_range(0, 16);
            end else if (snk_stall > 0) begin
                snk_stall--;
            end
            res_ch.ready <= (!sink_hold && snk_stall == 0);
        end
    end

    // Once, after 400 results, the receiver holds ready low while the sender
    // keeps offering, so the pipeline fills and stalls the sender.
    initial begin
        sink_hold = 1'b0;
        wait (results_seen >= 400);
        sink_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    // Stimulus, reset and end of run.
    initial begin
        int  gx;
        int  gy;
        int  a;
        int  b;
        int  kind;
        int  tmp;
        bit  calm;
        error_count = 0;
        i_rst_n = 1'b0;

        // Directed part: field extremes, every direction code, zero gradients,
        // the ratio boundaries and the edge of saturation.
        add_pixel(0, 0, $urandom_range(0, 16), 1'b0);
        add_pixel(1023, 1023, 0, 1'b0);
        add_pixel(-1024, -1024, 0, 1'b0);
        add_pixel(-1024, 1023, $urandom_range(0, 16), 1'b0);
        add_pixel(1023, -1024, 0, 1'b0);
        add_pixel(0, 1023, 0, 1'b0);
        add_pixel(0, -1024, $urandom_range(0, 16), 1'b0);
        add_pixel(0, 5, 0, 1'b0);
        add_pixel(5, 0, 0, 1'b0);
        add_pixel(-5, 0, 0, 1'b0);
        add_pixel(1023, 0, $urandom_range(0, 16), 1'b0);
        add_pixel(-1024, 0, 0, 1'b0);
        add_pixel(1, 1, 0, 1'b0);
        add_pixel(-1, 1, 0, 1'b0);
        add_pixel(1, 2, 0, 1'b0);
        add_pixel(1, 3, $urandom_range(0, 16), 1'b0);
        add_pixel(2, 1, 0, 1'b0);
        add_pixel(3, 1, 0, 1'b0);
        add_pixel(-1, -2, 0, 1'b0);
        add_pixel(-3, -1, 0, 1'b0);
        add_pixel(255, 0, $urandom_range(0, 16), 1'b0);
        add_pixel(256, 0, 0, 1'b0);
        add_pixel(181, 181, 0, 1'b0);
        add_pixel(-181, 182, 0, 1'b0);
        add_pixel(0, -256, 0, 1'b0);

        // Random part in stretches; some stretches run with no sender gaps.
        calm = 1'b0;
        for (int i = 0; i < 2000; i++) begin
            if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                // Any bit pattern of both words.
                gx = $urandom_range(0, 2047);
                gy = $urandom_range(0, 2047);
            end else if (kind <= 5) begin
                gx = int'($urandom_range(0, 16)) - 8;
                gy = int'($urandom_range(0, 16)) - 8;
            end else if (kind <= 7) begin
                // Right at the two-to-one ratio boundary.
                a = $urandom_range(0, 500);
                b = 2 * a + int'($urandom_range(0, 2)) - 1;
                if (b < 0) b = 0;
                if ($urandom_range(0, 1)) a = -a;
                if ($urandom_range(0, 1)) b = -b;
                if ($urandom_range(0, 1)) begin
                    gx = a;
                    gy = b;
                end else begin
                    gx = b;
                    gy = a;
                end
            end else begin
                // Squared sum close to the saturation point.
                a = int'($urandom_range(0, 512)) - 256;
                b = int'($floor($sqrt(65536.0 - a * a))) + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1)) b = -b;
                if ($urandom_range(0, 1)) begin
                    tmp = a;
                    a = b;
                    b = tmp;
                end
                gx = a;
                gy = b;
            end
            add_pixel(gx, gy, calm ? 0 : $urandom_range(0, 16), (i == 0) || (i == 1200));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is taken and every result is in, then let the
        // clock run on so that a stray result would still be seen. Sampling at the
        // falling edge sees the driver and the monitor settled.
        @(negedge i_clk);
        while (pixel_q.size() > 0 || grad_ch.valid || pending_results.size() > 0)
            @(negedge i_clk);
        repeat (4 * NUM_STAGES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("sobel_magnitude_direction_tb: done, clean");
        end else begin
            $display("sobel_magnitude_direction_tb: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("sobel_magnitude_direction_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
rtl/sobmd_pkg.sv
rtl/sobmd_if.sv
rtl/sobmd_grad_stage.sv
rtl/sobmd_sum_stage.sv
rtl/sobmd_sqrt_stage.sv
rtl/sobel_magnitude_direction.sv
dv/sobel_magnitude_direction_tb.sv
